@@ src/lsm_pkg.sv @@
package lsm_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [6:0] deviation;
    logic       error;
  } out_item_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MASK_WIDTH   = 3'd2;
  localparam logic [2:0] REG_MASK_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_MASK_BITS    = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch item, clear sums, reset scan counters
    logic scan;      // issue one mask point read
    logic acc;       // accumulate the read issued last cycle
    logic diff;      // form n*S2 and S1*S1
    logic sub;       // variance numerator
    logic sqrt_step; // one root step
    logic div_step;  // one quotient step
  } lsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic sqrt_last;
    logic div_last;
  } lsm_stat_t;

endpackage

@@ src/local_stddev_masked.sv @@
// Local standard deviation over a binary mask on a stored 8-bit frame.
// A query is accepted, then scans the mask_width*mask_height points (at least one, one
// frame read each), drains the last read, forms the two products and the variance
// numerator, and runs 14 root steps and 7 quotient steps before the result is offered.
// One item is processed at a time.
// Reset (synchronous, active high) restores the register defaults; the frame is
// undefined until written.
module local_stddev_masked
  import lsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MASK_SIDE  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lsm_cmd_t  cmd;
  lsm_stat_t stat;

  lsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_is_query(in_data.op == OP_QUERY), .out_valid(out_valid),
    .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lsm_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MASK_SIDE(MASK_SIDE)
  ) u_dp (
    .clk(clk), .rst(rst), .in_xfer(in_valid && in_ready), .in_item(in_data),
    .cfg_write(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .out_item(out_data)
  );

endmodule

@@ src/lsm_ctrl.sv @@
module lsm_ctrl
  import lsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_is_query,
  output logic      out_valid,
  input  logic      out_ready,
  input  lsm_stat_t stat,
  output lsm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DIFF, S_SUB, S_SQRT, S_DIV, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.start     = (state == S_IDLE) && in_valid && in_is_query;
    cmd.scan      = (state == S_SCAN);
    cmd.acc       = (state == S_DRAIN) || ((state == S_SCAN));
    cmd.diff      = (state == S_DIFF);
    cmd.sub       = (state == S_SUB);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.div_step  = (state == S_DIV);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid && in_is_query) state <= S_SCAN;
        S_SCAN: if (stat.scan_last) state <= S_DRAIN;
        S_DRAIN: state <= S_DIFF;
        S_DIFF: state <= S_SUB;
        S_SUB: state <= S_SQRT;
        S_SQRT: if (stat.sqrt_last) state <= S_DIV;
        S_DIV: if (stat.div_last) state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/lsm_datapath.sv @@
module lsm_datapath
  import lsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MASK_SIDE  = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_xfer,
  input  in_item_t  in_item,
  input  logic      cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  lsm_cmd_t  cmd,
  output lsm_stat_t stat,
  output out_item_t out_item
);

  localparam int XW = $clog2(MAX_WIDTH) + 1;
  localparam int YW = $clog2(MAX_HEIGHT) + 1;
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MSW = $clog2(MASK_SIDE + 1);
  localparam int CW = $clog2(MASK_SIDE) + 1;

  // Configuration registers
  logic [8:0]  image_width, image_height;
  logic [3:0]  mask_width, mask_height;
  logic [63:0] mask_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      mask_width   <= 4'd3;
      mask_height  <= 4'd3;
      mask_bits    <= 64'd511;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[8:0];
        REG_MASK_WIDTH:   mask_width   <= cfg_data[3:0];
        REG_MASK_HEIGHT:  mask_height  <= cfg_data[3:0];
        REG_MASK_BITS:    mask_bits    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping
  logic [12:0] w_eff, h_eff;
  logic [3:0]  mw_eff, mh_eff;
  always_comb begin
    w_eff  = (13'(image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(image_width);
    h_eff  = (13'(image_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(image_height);
    mw_eff = (mask_width > 4'(MASK_SIDE)) ? 4'(MASK_SIDE) : mask_width;
    mh_eff = (mask_height > 4'(MASK_SIDE)) ? 4'(MASK_SIDE) : mask_height;
  end

  logic in_image;
  assign in_image = (13'(in_item.col) < w_eff) && (13'(in_item.row) < h_eff);

  // Frame memory
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW+1:0] wr_lin;
  assign wr_lin = (AW+2)'(in_item.row) * (AW+2)'(MAX_WIDTH) + (AW+2)'(in_item.col);

  always_ff @(posedge clk) begin
    if (in_xfer && in_item.op == OP_WRITE && in_image) mem[wr_lin[AW-1:0]] <= in_item.pixel;
    rd_data <= mem[rd_addr];
  end

  // Query latch and mask scan
  logic [7:0]  qcol, qrow;
  logic        q_err;
  logic [3:0]  ci, rj;
  logic [6:0]  bidx;
  logic [6:0]  n;
  logic        acc_v;
  logic [13:0] s1;
  logic [21:0] s2;

  logic signed [14:0] k, l;
  logic pt_set, pt_in;
  always_comb begin
    k = 15'(qcol) + 15'(ci) - 15'(mw_eff >> 1);
    l = 15'(qrow) + 15'(rj) - 15'(mh_eff >> 1);
    pt_set = (mw_eff != 0) && (mh_eff != 0) && mask_bits[bidx[5:0]];
    pt_in = (k >= 0) && (l >= 0) && (15'(w_eff) > k) && (15'(h_eff) > l);
    rd_addr = AW'(32'(l[13:0]) * 32'(MAX_WIDTH) + 32'(k[13:0]));
  end
  assign stat.scan_last = (mw_eff == 0) || (mh_eff == 0) ||
                          ((ci == mw_eff - 4'd1) && (rj == mh_eff - 4'd1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qcol <= in_item.col;
      qrow <= in_item.row;
      q_err <= !in_image;
      ci <= '0; rj <= '0; bidx <= '0;
      n <= '0; s1 <= '0; s2 <= '0; acc_v <= 1'b0;
    end else begin
      if (cmd.acc && acc_v) begin
        s1 <= s1 + 14'(rd_data);
        s2 <= s2 + 22'(rd_data * rd_data);
      end
      acc_v <= cmd.scan && pt_set && pt_in;
      if (cmd.scan) begin
        if (pt_set) n <= n + 7'd1;
        bidx <= bidx + 7'd1;
        if (ci == mw_eff - 4'd1) begin
          ci <= '0;
          rj <= rj + 4'd1;
        end else begin
          ci <= ci + 4'd1;
        end
      end
    end
  end

  // Variance numerator, root and quotient
  logic [26:0] prod_a, prod_b;
  logic [27:0] dval;
  logic [26:0] rem;
  logic [13:0] root;
  logic [3:0]  sq_cnt;
  logic [6:0]  quo;
  logic [13:0] drem;
  logic [2:0]  dv_cnt;

  logic [27:0] sq_trial;
  logic [27:0] sq_rem_sh;
  always_comb begin
    sq_rem_sh = {rem[25:0], dval[27:26]} ;
    sq_trial  = {root, 2'b01};
  end

  assign stat.sqrt_last = (sq_cnt == 4'd13);
  assign stat.div_last  = (dv_cnt == 3'd6);

  logic [14:0] dr_sh;
  assign dr_sh = {drem, root[6 - dv_cnt]};
  logic [14:0] dr_sh2;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      prod_a <= 27'(n) * 27'(s2);
      prod_b <= 27'(s1) * 27'(s1);
    end
    if (cmd.sub) begin
      dval <= {1'b0, prod_a - prod_b};
      rem <= '0;
      root <= '0;
      sq_cnt <= '0;
    end
    // Restoring root: two bits of the radicand per step
    if (cmd.sqrt_step) begin
      dval <= {dval[25:0], 2'b00};
      sq_cnt <= sq_cnt + 4'd1;
      if (sq_rem_sh >= sq_trial) begin
        rem  <= 27'(sq_rem_sh - sq_trial);
        root <= {root[12:0], 1'b1};
      end else begin
        rem  <= sq_rem_sh[26:0];
        root <= {root[12:0], 1'b0};
      end
      drem <= '0;
      dv_cnt <= '0;
      quo <= '0;
    end
    // Quotient root/n: root < 2^14, quotient < 2^7; high 7 bits first
    if (cmd.div_step) begin
      dv_cnt <= dv_cnt + 3'd1;
      if (dr_sh2 >= 15'(n)) begin
        drem <= 14'(dr_sh2 - 15'(n));
        quo  <= {quo[5:0], 1'b1};
      end else begin
        drem <= dr_sh2[13:0];
        quo  <= {quo[5:0], 1'b0};
      end
    end
  end

  // Preload remainder with the top 7 root bits (value < n*128 holds since quotient < 128)
  assign dr_sh2 = (dv_cnt == 3'd0) ? {1'b0, 7'd0, root[13:7]} * 15'd2
                                     + 15'(root[6]) : dr_sh;

  logic n_zero;
  assign n_zero = (n == 7'd0);
  assign out_item.error = q_err || n_zero;
  assign out_item.deviation = out_item.error ? 7'd0 : quo;

  logic unused;
  assign unused = ^{rst, MSW, CW, XW, YW};

endmodule

@@ tb/local_stddev_masked_checker.sv @@
module local_stddev_masked_checker
  import lsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          queries_seen,
  output int          errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = 256;
  localparam int FRAME_H = 256;
  localparam int MASK_MAX = 8;

  // predictor copy of the frame and the registers
  logic [7:0]  frame_copy [0:FRAME_W*FRAME_H-1];
  logic [8:0]  img_w, img_h;
  logic [3:0]  msk_w, msk_h;
  logic [63:0] msk_bits;
  out_item_t   deviation_q [$];

  initial begin
    fails = 0;
    pending = 0;
    queries_seen = 0;
    errors_seen = 0;
  end

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic out_item_t deviation_of(in_item_t it);
    out_item_t res;
    int w, h, mw, mh, l, k;
    longint unsigned n, s1, s2, g;
    w = (img_w > FRAME_W) ? FRAME_W : img_w;
    h = (img_h > FRAME_H) ? FRAME_H : img_h;
    mw = (msk_w > MASK_MAX) ? MASK_MAX : msk_w;
    mh = (msk_h > MASK_MAX) ? MASK_MAX : msk_h;
    n = 0;
    s1 = 0;
    s2 = 0;
    res.deviation = '0;
    res.error = 1'b1;
    if (it.col >= w || it.row >= h) return res;
    for (int j = 0; j < mh; j++) begin
      for (int i = 0; i < mw; i++) begin
        if (msk_bits[(j * mw + i) % 64]) begin
          n++;
          l = it.row + j - mh / 2;
          k = it.col + i - mw / 2;
          if (l >= 0 && l < h && k >= 0 && k < w) begin
            g = frame_copy[l * FRAME_W + k];
            s1 += g;
            s2 += g * g;
          end
        end
      end
    end
    if (n == 0) return res;
    res.deviation = 7'(root_floor(n * s2 - s1 * s1) / n);
    res.error = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      img_w = 9'd256;
      img_h = 9'd256;
      msk_w = 4'd3;
      msk_h = 4'd3;
      msk_bits = 64'd511;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w = cfg_data[8:0];
          REG_IMAGE_HEIGHT: img_h = cfg_data[8:0];
          REG_MASK_WIDTH:   msk_w = cfg_data[3:0];
          REG_MASK_HEIGHT:  msk_h = cfg_data[3:0];
          REG_MASK_BITS:    msk_bits = cfg_data;
          default: ;
        endcase
      end
      // input transfer: store pixel or predict a result
      if (in_valid && in_ready) begin
        if (in_data.op == OP_WRITE) begin
          if (in_data.col < ((img_w > FRAME_W) ? FRAME_W : img_w) &&
              in_data.row < ((img_h > FRAME_H) ? FRAME_H : img_h))
            frame_copy[in_data.row * FRAME_W + in_data.col] = in_data.pixel;
        end else begin
          deviation_q.push_back(deviation_of(in_data));
          queries_seen++;
        end
      end
      // output transfer: compare against oldest prediction
      if (out_valid && out_ready) begin
        if (deviation_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result dev=%0d err=%0b", $realtime,
                     out_data.deviation, out_data.error);
        end else begin
          want = deviation_q.pop_front();
          if (want.error) errors_seen++;
          if (out_data.deviation !== want.deviation || out_data.error !== want.error) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch dev exp %0d got %0d, err exp %0b got %0b",
                       $realtime, want.deviation, out_data.deviation,
                       want.error, out_data.error);
          end
        end
      end
    end
    pending = deviation_q.size();
  end

endmodule

@@ tb/local_stddev_masked_tb.sv @@
module local_stddev_masked_tb;
  import lsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int fails, pending, queries_seen, errors_seen;
  bit no_gaps = 1'b0;
  int results_taken = 0;

  // stimulus-side view of registers and of which pixels hold data
  int          img_w = 256, img_h = 256, msk_w = 3, msk_h = 3;
  logic [63:0] msk_bits = 64'd511;
  bit          written [0:65535];

  always #6 clk = ~clk;

  local_stddev_masked dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  local_stddev_masked_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .fails, .pending,
    .queries_seen, .errors_seen
  );

  function automatic int gap_draw();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] grey_draw();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int eff_w();
    return img_w > 256 ? 256 : img_w;
  endfunction

  function automatic int eff_h();
    return img_h > 256 ? 256 : img_h;
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic send(in_item_t it);
    int k;
    k = gap_draw();
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_pixel(int c, int r, logic [7:0] g);
    in_item_t it;
    it.op = OP_WRITE;
    it.col = 8'(c);
    it.row = 8'(r);
    it.pixel = g;
    send(it);
    if (c < eff_w() && r < eff_h()) written[r * 256 + c] = 1'b1;
  endtask

  // fills any unwritten pixel under the mask of an in-image query, then queries
  task automatic ask_deviation(int c, int r);
    in_item_t it;
    int mw, mh, l, k;
    mw = msk_w > 8 ? 8 : msk_w;
    mh = msk_h > 8 ? 8 : msk_h;
    if (c < eff_w() && r < eff_h()) begin
      for (int j = 0; j < mh; j++)
        for (int i = 0; i < mw; i++) begin
          l = r + j - mh / 2;
          k = c + i - mw / 2;
          if (msk_bits[(j * mw + i) % 64] && l >= 0 && l < eff_h() && k >= 0 &&
              k < eff_w() && !written[l * 256 + k])
            put_pixel(k, l, grey_draw());
        end
    end
    it.op = OP_QUERY;
    it.col = 8'(c);
    it.row = 8'(r);
    it.pixel = 8'($urandom_range(0, 255));
    send(it);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  img_w = val[8:0];
      REG_IMAGE_HEIGHT: img_h = val[8:0];
      REG_MASK_WIDTH:   msk_w = val[3:0];
      REG_MASK_HEIGHT:  msk_h = val[3:0];
      REG_MASK_BITS:    msk_bits = val;
      default: ;
    endcase
  endtask

  // let every expected result come, then the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic setup(int w, int h, int mw, int mh, logic [63:0] bits);
    drain();
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
    reg_write(REG_MASK_WIDTH, mw);
    reg_write(REG_MASK_HEIGHT, mh);
    reg_write(REG_MASK_BITS, bits);
  endtask

  // random mix: mostly queries in or near the image, some at the far edge or beyond
  task automatic random_items(int count, int span);
    int c, r, lim_c, lim_r, far_c, far_r;
    for (int n = 0; n < count; n++) begin
      lim_c = (eff_w() > 0) ? eff_w() - 1 : 0;
      lim_r = (eff_h() > 0) ? eff_h() - 1 : 0;
      far_c = lim_c;
      far_r = lim_r;
      if (span < lim_c) lim_c = span;
      if (span < lim_r) lim_r = span;
      if ($urandom_range(0, 9) < 2) begin
        c = $urandom_range(far_c, 255);
        r = $urandom_range(far_r, 255);
      end else begin
        c = $urandom_range(0, lim_c);
        r = $urandom_range(0, lim_r);
      end
      if ($urandom_range(0, 9) < 3) put_pixel(c, r, grey_draw());
      else ask_deviation(c, r);
    end
  endtask

  // result side: random stalls, one long hold-off that backs up the input
  initial begin
    int k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      k = (results_taken == 30) ? 400 : gap_draw();
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  initial begin
    #40ms;
    $display("local_stddev_masked_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: checkerboard of extremes, corners, far edge
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        put_pixel(c, r, ((r + c) % 2) ? 8'd255 : 8'd0);
    ask_deviation(1, 1);
    ask_deviation(0, 0);
    put_pixel(255, 255, 8'd255);
    put_pixel(254, 255, 8'd0);
    put_pixel(255, 254, 8'hAA);
    put_pixel(254, 254, 8'h55);
    ask_deviation(255, 255);
    ask_deviation(254, 254);
    ask_deviation(128, 127);

    // two-point mask reaches the top deviation
    setup(32, 32, 2, 1, 64'd3);
    put_pixel(4, 4, 8'd0);
    put_pixel(5, 4, 8'd255);
    ask_deviation(5, 4);
    ask_deviation(31, 31);
    ask_deviation(32, 0);
    ask_deviation(0, 200);
    drain();
    reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    random_items(30, 255);

    // assorted settings, the extremes among them
    setup(16, 12, 3, 3, 64'($urandom()));
    random_items(30, 255);
    no_gaps = 1'b1;
    random_items(15, 255);
    no_gaps = 1'b0;
    setup(1, 1, 1, 1, 64'd1);
    random_items(20, 255);
    setup(511, 300, 8, 8, '1);
    random_items(25, 6);
    setup(0, 5, 2, 2, 64'hF);
    random_items(20, 255);
    setup(20, 256, 0, 4, '1);
    random_items(20, 255);
    setup(8, 8, 15, 5, {$urandom(), $urandom()});
    random_items(30, 255);
    setup(40, 7, 5, 3, 64'd0);
    random_items(20, 255);
    setup(256, 256, 8, 8, {$urandom(), $urandom()});
    random_items(25, 6);
    setup(64, 64, 4, 7, {$urandom(), $urandom()});
    no_gaps = 1'b1;
    random_items(25, 10);
    no_gaps = 1'b0;
    random_items(25, 10);

    drain();
    $display("covered %0d queries (%0d flagged) over ten register settings",
             queries_seen, errors_seen);
    $display("stalls on both sides, one long output hold-off");
    if (fails == 0 && pending == 0) begin
      $display("local_stddev_masked_tb: done, clean");
    end else begin
      $display("local_stddev_masked_tb: done, errors");
    end
    $finish;
  end

endmodule
